FILE: hw/rtl/ntt_pkg.sv
// Shared types, constants and helpers for the name-to-task table.
// Used by ntt_ctrl and name_to_task_table; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ntt_pkg;

  // Table geometry.
  localparam int TABLE_ENTRIES = 128;
  localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
  localparam int COUNT_BITS    = $clog2(TABLE_ENTRIES + 1);

  // Field widths.
  localparam int KEY_BITS     = 32;
  localparam int KEY_BYTES    = KEY_BITS / 8;
  localparam int NAME_BYTES   = 4;
  localparam int NAME_BITS    = 8 * NAME_BYTES;
  localparam int KEPT_BYTES   = (NAME_BYTES < KEY_BYTES) ? NAME_BYTES : KEY_BYTES;
  localparam int TASK_BITS    = 8;
  localparam int SENDER_BITS  = 8;
  localparam int FOUND_BITS   = 8;
  localparam int CMD_BITS     = 2;

  // Request codes.
  localparam logic [CMD_BITS-1:0] CMD_LOOKUP   = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_REGISTER = 2'd1;

  // Result codes.
  typedef enum logic [2:0] {
    ST_FOUND       = 3'd0,
    ST_NOT_FOUND   = 3'd1,
    ST_ADDED       = 3'd2,
    ST_OVERWRITTEN = 3'd3,
    ST_FULL        = 3'd4,
    ST_IGNORED     = 3'd5
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  // One table entry as stored in memory.
  typedef struct packed {
    logic [TASK_BITS-1:0] task_id;
    logic [NAME_BITS-1:0] name;
  } entry_t;

  // Result handed from the controller to the output register.
  typedef struct packed {
    logic                  load;
    status_t               status;
    logic [FOUND_BITS-1:0] found;
  } res_t;

  // Keep name bytes up to the first zero byte and clear everything after it.
  function automatic logic [NAME_BITS-1:0] canon_name(input logic [KEY_BITS-1:0] key);
    logic [NAME_BITS-1:0] r;
    logic                 ended;
    logic [7:0]           b;
    r     = '0;
    ended = 1'b0;
    for (int i = 0; i < KEPT_BYTES; i++) begin
      b = key[8*i +: 8];
      if (b == 8'd0) begin
        ended = 1'b1;
      end
      if (!ended) begin
        r[8*i +: 8] = b;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ntt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ntt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ntt_ctrl.sv
// Request sequencer: scans the table memory one entry per cycle and writes back.
// Depends on ntt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ntt_ctrl (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output      logic                             in_stall,
  input  wire logic [ntt_pkg::CMD_BITS-1:0]     command,
  input  wire logic [ntt_pkg::KEY_BITS-1:0]     name_key,
  input  wire logic [ntt_pkg::SENDER_BITS-1:0]  sender_task,
  input  wire logic                             out_free,
  output      ntt_pkg::res_t                    res,
  output      logic [ntt_pkg::IDX_BITS-1:0]     rd_addr,
  input  wire ntt_pkg::entry_t                  rd_data,
  output      logic                             wr_en,
  output      logic [ntt_pkg::IDX_BITS-1:0]     wr_addr,
  output      ntt_pkg::entry_t                  wr_data
);

  import ntt_pkg::*;

  state_t                state;
  state_t                state_next;
  logic [CMD_BITS-1:0]   cmd_q;
  logic [NAME_BITS-1:0]  name_q;
  logic [TASK_BITS-1:0]  task_q;
  logic [COUNT_BITS-1:0] count;
  logic [IDX_BITS-1:0]   scan_idx;
  logic                  hit;
  logic [TASK_BITS-1:0]  hit_task;
  logic                  match;
  logic                  last;
  logic                  has_room;
  logic                  searchable;

  // Compare of the entry that arrives from memory this cycle.
  assign match      = (rd_data.name == name_q);
  assign last       = ((COUNT_BITS'(scan_idx) + COUNT_BITS'(1)) == count);
  assign has_room   = (count < COUNT_BITS'(TABLE_ENTRIES));
  assign searchable = ((command == CMD_LOOKUP) || (command == CMD_REGISTER)) &&
                      (count != '0);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = searchable ? S_SCAN : S_FINISH;
        end
      end
      S_SCAN: begin
        if (match || last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Handshake, memory access and result.
  always_comb begin
    in_stall   = 1'b1;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = scan_idx;
    wr_data    = '{task_id: task_q, name: name_q};
    res.load   = 1'b0;
    res.status = ST_IGNORED;
    res.found  = '0;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
      end
      S_SCAN: begin
        rd_addr = scan_idx + IDX_BITS'(1);
      end
      S_FINISH: begin
        res.load = out_free;
        case (cmd_q)
          CMD_LOOKUP: begin
            if (hit) begin
              res.status = ST_FOUND;
              res.found  = FOUND_BITS'(hit_task);
            end else begin
              res.status = ST_NOT_FOUND;
            end
          end
          CMD_REGISTER: begin
            if (hit) begin
              res.status = ST_OVERWRITTEN;
              wr_en      = out_free;
            end else if (has_room) begin
              res.status = ST_ADDED;
              wr_en      = out_free;
              wr_addr    = count[IDX_BITS-1:0];
            end else begin
              res.status = ST_FULL;
            end
          end
          default: res.status = ST_IGNORED;
        endcase
      end
      default: in_stall = 1'b1;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      hit   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && in_valid) begin
        hit <= 1'b0;
      end else if (state == S_SCAN && match) begin
        hit <= 1'b1;
      end
      if (state == S_FINISH && out_free && cmd_q == CMD_REGISTER && !hit && has_room) begin
        count <= count + COUNT_BITS'(1);
      end
    end
  end

  // Request and scan registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cmd_q    <= command;
      name_q   <= canon_name(name_key);
      task_q   <= TASK_BITS'(sender_task);
      scan_idx <= '0;
    end else if (state == S_SCAN) begin
      if (match) begin
        hit_task <= rd_data.task_id;
      end else begin
        scan_idx <= scan_idx + IDX_BITS'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/name_to_task_table.sv
// Top level of the name-to-task table: table memory, sequencer, output register.
// Depends on ntt_pkg, ntt_ram and ntt_ctrl.
//
// Usage:
//   Each input item carries a command (lookup, register or other), a name key
//   of up to four bytes and the sender's task id. Each item yields exactly one
//   result item with a status code and, on a found lookup, the stored task id.
//   Both channels use valid/stall; an item moves when valid is high and stall
//   is low.
//   One item is worked on at a time. After acceptance the sequencer reads the
//   table memory one entry per cycle until the first match or the last filled
//   entry, then decides and writes back once the output register is free.
//   Other commands and an empty table skip the scan; a full table holds 128
//   entries. The single read port of the table memory sets the scan rate.
//   The result is valid in the cycle after the write-back cycle.
//   Reset empties the table at once through the fill count; no clearing pass.
//   A stalled result holds in the output register; the next item may be
//   accepted and scanned meanwhile, and waits in its final cycle until the
//   output register frees up.
`timescale 1ns / 1ps
`default_nettype none

module name_to_task_table (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output      logic                             in_stall,
  input  wire logic [ntt_pkg::CMD_BITS-1:0]     command,
  input  wire logic [ntt_pkg::KEY_BITS-1:0]     name_key,
  input  wire logic [ntt_pkg::SENDER_BITS-1:0]  sender_task,
  output      logic                             out_valid,
  input  wire logic                             out_stall,
  output      ntt_pkg::status_t                 status,
  output      logic [ntt_pkg::FOUND_BITS-1:0]   found_task
);

  import ntt_pkg::*;

  res_t                res;
  logic                out_free;
  logic [IDX_BITS-1:0] rd_addr;
  logic [IDX_BITS-1:0] wr_addr;
  logic                wr_en;
  entry_t              rd_data;
  entry_t              wr_data;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid || !out_stall;

  // Table memory: name and task id of each entry side by side.
  ntt_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  ntt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .name_key   (name_key),
    .sender_task(sender_task),
    .out_free   (out_free),
    .res        (res),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (res.load) begin
      status     <= res.status;
      found_task <= res.found;
    end
  end

endmodule

`default_nettype wire
